[rtl/rlpd_pkg.sv]
// Shared constants, types and helpers of the row line position detector.
`timescale 1ns / 1ps
package rlpd_pkg;

  localparam int KERNEL_MAX_DEF  = 15;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_CENTERS_DEF = 512;
  localparam int MAX_LINES_DEF   = 32;

  localparam int CNT_W      = 5;
  localparam int ACC_W      = 10;
  localparam int POS_W      = 10;
  localparam int LCNT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int QDEPTH     = 4;

  localparam logic [CNT_W-1:0] MIN_COUNT_RST = 5'd2;
  localparam logic [ACC_W-1:0] REJECT_RST    = 10'd450;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    F_RUN,
    F_FLUSH,
    F_CLOSE,
    F_END,
    F_WAIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NEXT,
    B_CEN,
    B_SUM,
    B_TAIL,
    B_DEC,
    B_SUMMARY
  } back_state_t;

  // Floor division by 255, exact for values below 65280.
  function automatic logic [15:0] div255(input logic [15:0] s);
    return (s + 16'd1 + (s >> 8)) >> 8;
  endfunction

endpackage

[rtl/rlpd_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module rlpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/rlpd_queue.sv]
// Short event queue between the pixel front end and the validation back end.
`timescale 1ns / 1ps
module rlpd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty,
  output logic             full
);
  import rlpd_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] slot_r [QDEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [PW:0]      cnt_r;

  assign dout      = slot_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

[rtl/rlpd_front.sv]
// Front end: takes pixels, keeps the box window, writes counts and finds run centers.
`timescale 1ns / 1ps
module rlpd_front #(
  parameter int KERNEL_MAX = rlpd_pkg::KERNEL_MAX_DEF,
  parameter int MAX_WIDTH  = rlpd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [7:0]                                pixel,
  input  logic                                      row_last,
  input  logic [rlpd_pkg::CNT_W-1:0]                min_count,
  output logic                                      ev_push,
  output logic [$clog2(MAX_WIDTH+1)+1:0]            ev_data,
  output logic                                      cs_we,
  output logic [$clog2(MAX_WIDTH)-1:0]              cs_waddr,
  output logic [rlpd_pkg::CNT_W-1:0]                cs_wdata,
  input  logic                                      back_done
);
  import rlpd_pkg::*;

  localparam int HALF  = (KERNEL_MAX - 1) / 2;
  localparam int WLEN  = 2 * HALF + 1;
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int FED_W = $clog2(MAX_WIDTH + HALF + 1);
  localparam int SUM_W = $clog2(WLEN * 255 + 1);
  localparam int FL_W  = $clog2(HALF + 1);

  front_state_t     state_r, state_nxt;
  logic [7:0]       win_r [WLEN];
  logic [SUM_W-1:0] sum_r;
  logic [FED_W-1:0] fed_r;
  logic [COL_W-1:0] col_r;
  logic             run_r;
  logic [COL_W-1:0] rstart_r;
  logic             drop_r;
  logic [FL_W-1:0]  fl_r;

  logic             accept;
  logic             feed_en;
  logic [7:0]       feed_v;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt;
  logic             cnt_ok;
  logic [FED_W-1:0] x;
  logic [COL_W-1:0] x_col;
  logic             cand;
  logic [COL_W-1:0] run_end;
  logic [COL_W-1:0] mid;
  logic             col_room;

  assign col_room = (col_r < COL_W'(MAX_WIDTH));
  assign sum_nxt  = sum_r + SUM_W'(feed_v) - SUM_W'(win_r[WLEN-1]);
  assign cnt      = CNT_W'(div255(16'(sum_nxt)));
  assign x        = fed_r - FED_W'(HALF);
  assign x_col    = x[COL_W-1:0];
  assign cnt_ok   = feed_en && (fed_r >= FED_W'(HALF));
  assign cand     = (cnt > min_count) && (cnt <= CNT_W'(KERNEL_MAX));
  assign run_end  = (state_r == F_CLOSE) ? col_r : x_col;
  assign mid      = rstart_r + ((run_end - rstart_r) >> 1);
  assign busy     = (state_r != F_RUN);

  assign cs_we    = cnt_ok;
  assign cs_waddr = x[AW-1:0];
  assign cs_wdata = cnt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_RUN: begin
        if (start && row_last) begin
          state_nxt = F_FLUSH;
        end
      end
      F_FLUSH: begin
        if (fl_r == FL_W'(HALF - 1)) begin
          state_nxt = F_CLOSE;
        end
      end
      F_CLOSE: state_nxt = F_END;
      F_END:   state_nxt = F_WAIT;
      F_WAIT: begin
        if (back_done) begin
          state_nxt = F_RUN;
        end
      end
      default: state_nxt = F_RUN;
    endcase
  end

  always_comb begin
    accept  = 1'b0;
    feed_en = 1'b0;
    feed_v  = 8'd0;
    ev_push = 1'b0;
    ev_data = {1'b0, 1'b0, mid};
    unique case (state_r)
      F_RUN: begin
        accept  = start;
        feed_en = start && col_room;
        feed_v  = pixel;
        ev_push = cnt_ok && !cand && run_r;
      end
      F_FLUSH: begin
        feed_en = 1'b1;
        ev_push = cnt_ok && !cand && run_r;
      end
      F_CLOSE: ev_push = run_r;
      F_END: begin
        ev_push = 1'b1;
        ev_data = {1'b1, drop_r, col_r};
      end
      F_WAIT: ev_push = 1'b0;
      default: ev_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_RUN;
      sum_r    <= '0;
      fed_r    <= '0;
      col_r    <= '0;
      run_r    <= 1'b0;
      rstart_r <= '0;
      drop_r   <= 1'b0;
      fl_r     <= '0;
      for (int i = 0; i < WLEN; i++) begin
        win_r[i] <= 8'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (feed_en) begin
        win_r[0] <= feed_v;
        for (int i = 1; i < WLEN; i++) begin
          win_r[i] <= win_r[i-1];
        end
        sum_r <= sum_nxt;
        fed_r <= fed_r + 1'b1;
      end
      if (accept) begin
        if (col_room) begin
          col_r <= col_r + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cnt_ok) begin
        if (cand && !run_r) begin
          run_r    <= 1'b1;
          rstart_r <= x_col;
        end else if (!cand && run_r) begin
          run_r <= 1'b0;
        end
      end
      if (state_r == F_CLOSE) begin
        run_r <= 1'b0;
      end
      if (state_r == F_FLUSH) begin
        fl_r <= fl_r + 1'b1;
      end else begin
        fl_r <= '0;
      end
      if (state_r == F_WAIT && back_done) begin
        sum_r  <= '0;
        fed_r  <= '0;
        col_r  <= '0;
        run_r  <= 1'b0;
        drop_r <= 1'b0;
        for (int i = 0; i < WLEN; i++) begin
          win_r[i] <= 8'd0;
        end
      end
    end
  end
endmodule

[rtl/rlpd_back.sv]
// Back end: stores run centers, validates them at row end and emits the results.
`timescale 1ns / 1ps
module rlpd_back #(
  parameter int KERNEL_MAX  = rlpd_pkg::KERNEL_MAX_DEF,
  parameter int MAX_WIDTH   = rlpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CENTERS = rlpd_pkg::MAX_CENTERS_DEF,
  parameter int MAX_LINES   = rlpd_pkg::MAX_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ev_valid,
  input  logic [$clog2(MAX_WIDTH+1)+1:0]    ev_data,
  output logic                              ev_pop,
  input  logic [rlpd_pkg::ACC_W-1:0]        reject_limit,
  output logic [$clog2(MAX_WIDTH)-1:0]      cs_raddr,
  input  logic [rlpd_pkg::CNT_W-1:0]        cs_rdata,
  output logic                              done,
  output logic                              out_valid,
  output logic [rlpd_pkg::POS_W-1:0]        out_line_position,
  output logic [rlpd_pkg::LCNT_W-1:0]       out_line_count,
  output logic                              out_row_end,
  output logic                              out_overflow
);
  import rlpd_pkg::*;

  localparam int DELTA = KERNEL_MAX / 2;
  localparam int SPAN  = 2 * DELTA + 1;
  localparam int SP_W  = $clog2(SPAN);
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_CENTERS + 1);
  localparam int CA    = $clog2(MAX_CENTERS);
  localparam int LW    = $clog2(MAX_LINES + 1);

  back_state_t      state_r, state_nxt;
  logic [CW-1:0]    ctot_r;
  logic [CW-1:0]    idx_r;
  logic [COL_W-1:0] width_r;
  logic             drop_r;
  logic [ACC_W-1:0] acc_r;
  logic [LW-1:0]    ltot_r;
  logic [COL_W-1:0] k_r;
  logic [SP_W-1:0]  iss_r;
  logic             rdv_r;
  logic [COL_W-1:0] cen_r;

  logic             ev_end;
  logic             ev_drop;
  logic [COL_W-1:0] ev_val;
  logic             cl_we;
  logic [COL_W-1:0] cl_rdata;
  logic             in_range;
  logic [COL_W+POS_W-1:0] cen_ext;

  assign ev_end  = ev_data[COL_W+1];
  assign ev_drop = ev_data[COL_W];
  assign ev_val  = ev_data[COL_W-1:0];
  assign cen_ext = {{POS_W{1'b0}}, cen_r};

  assign ev_pop   = (state_r == B_IDLE) && ev_valid;
  assign cl_we    = ev_pop && !ev_end && (ctot_r < CW'(MAX_CENTERS));
  assign cs_raddr = k_r[AW-1:0];
  assign done     = (state_r == B_SUMMARY);
  assign in_range = (cl_rdata > COL_W'(DELTA)) &&
                    (({1'b0, cl_rdata} + (COL_W+1)'(DELTA)) < {1'b0, width_r});

  rlpd_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_CENTERS)
  ) u_center_list (
    .clk   (clk),
    .we    (cl_we),
    .waddr (ctot_r[CA-1:0]),
    .wdata (ev_val),
    .raddr (idx_r[CA-1:0]),
    .rdata (cl_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (ev_valid && ev_end) begin
          state_nxt = B_NEXT;
        end
      end
      B_NEXT: state_nxt = (idx_r == ctot_r) ? B_SUMMARY : B_CEN;
      B_CEN:  state_nxt = in_range ? B_SUM : B_NEXT;
      B_SUM: begin
        if (iss_r == SP_W'(SPAN - 1)) begin
          state_nxt = B_TAIL;
        end
      end
      B_TAIL:    state_nxt = B_DEC;
      B_DEC:     state_nxt = B_NEXT;
      B_SUMMARY: state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      ctot_r    <= '0;
      idx_r     <= '0;
      drop_r    <= 1'b0;
      ltot_r    <= '0;
      rdv_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rdv_r     <= (state_r == B_SUM);
      out_valid <= 1'b0;
      if (rdv_r) begin
        acc_r <= acc_r + ACC_W'(cs_rdata);
      end
      case (state_r)
        B_IDLE: begin
          if (ev_valid) begin
            if (ev_end) begin
              width_r <= ev_val;
              drop_r  <= drop_r | ev_drop;
              idx_r   <= '0;
            end else if (ctot_r < CW'(MAX_CENTERS)) begin
              ctot_r <= ctot_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        B_CEN: begin
          cen_r <= cl_rdata;
          k_r   <= cl_rdata - COL_W'(DELTA);
          iss_r <= '0;
          acc_r <= '0;
          if (!in_range) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        B_SUM: begin
          k_r   <= k_r + 1'b1;
          iss_r <= iss_r + 1'b1;
        end
        B_DEC: begin
          idx_r <= idx_r + 1'b1;
          if (acc_r < reject_limit) begin
            if (ltot_r < LW'(MAX_LINES)) begin
              ltot_r            <= ltot_r + 1'b1;
              out_valid         <= 1'b1;
              out_line_position <= cen_ext[POS_W-1:0];
              out_line_count    <= '0;
              out_row_end       <= 1'b0;
              out_overflow      <= 1'b0;
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        B_SUMMARY: begin
          out_valid         <= 1'b1;
          out_line_position <= '0;
          out_line_count    <= LCNT_W'(ltot_r);
          out_row_end       <= 1'b1;
          out_overflow      <= drop_r;
          ctot_r            <= '0;
          ltot_r            <= '0;
          drop_r            <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/row_line_position_detector.sv]
// Top level of the row line position detector.
`timescale 1ns / 1ps
// Usage. A row enters one pixel per beat: a beat is taken at a clock edge with
// start high and busy low, and in_row_last marks the last pixel of the row.
// While a row streams in, busy stays low, so one pixel can enter every cycle.
// After the last pixel the block raises busy. It flushes the box window in its
// flush state and closes the open run in its close and end states. Then it
// checks each stored run center: a center outside the row margins passes only
// the next and center states, any other center also the sum, tail and decide
// states, as its window of counts is read one entry per cycle from the count
// memory's single read port. The number of centers sets the row-end latency.
// Each accepted line leaves as one beat on the out_ ports, flagged by out_valid
// for exactly one cycle; the receiver cannot stall them. A summary beat with
// out_row_end high closes the row, and busy drops in that same cycle.
// Configuration goes through the cfg_ channel, which is always ready and must
// be used only while the block is idle. Reset restores the register defaults
// and clears all row state; the count and center memories need no clearing.
module row_line_position_detector #(
  parameter int KERNEL_MAX  = rlpd_pkg::KERNEL_MAX_DEF,
  parameter int MAX_WIDTH   = rlpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CENTERS = rlpd_pkg::MAX_CENTERS_DEF,
  parameter int MAX_LINES   = rlpd_pkg::MAX_LINES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [7:0]                         in_pixel,
  input  logic                               in_row_last,
  output logic                               out_valid,
  output logic [rlpd_pkg::POS_W-1:0]         out_line_position,
  output logic [rlpd_pkg::LCNT_W-1:0]        out_line_count,
  output logic                               out_row_end,
  output logic                               out_overflow,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rlpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rlpd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int EV_W  = COL_W + 2;

  logic [CNT_W-1:0] min_count_r;
  logic [ACC_W-1:0] reject_limit_r;

  // Event path from the front end to the back end.
  logic             ev_push;
  logic [EV_W-1:0]  ev_wdata;
  logic             ev_pop;
  logic [EV_W-1:0]  ev_rdata;
  logic             ev_valid;
  logic             q_full;

  // Count memory: written by the front end, read by the back end at row end.
  logic             cs_we;
  logic [AW-1:0]    cs_waddr;
  logic [CNT_W-1:0] cs_wdata;
  logic [AW-1:0]    cs_raddr;
  logic [CNT_W-1:0] cs_rdata;
  logic             back_done;

  assign cfg_ready = 1'b1;

  // Writes to an index past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r    <= MIN_COUNT_RST;
      reject_limit_r <= REJECT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_COUNT:    min_count_r    <= cfg_data[CNT_W-1:0];
        REG_REJECT_LIMIT: reject_limit_r <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  rlpd_front #(
    .KERNEL_MAX (KERNEL_MAX),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .pixel     (in_pixel),
    .row_last  (in_row_last),
    .min_count (min_count_r),
    .ev_push   (ev_push),
    .ev_data   (ev_wdata),
    .cs_we     (cs_we),
    .cs_waddr  (cs_waddr),
    .cs_wdata  (cs_wdata),
    .back_done (back_done)
  );

  rlpd_queue #(
    .WIDTH (EV_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .din       (ev_wdata),
    .pop       (ev_pop),
    .dout      (ev_rdata),
    .not_empty (ev_valid),
    .full      (q_full)
  );

  rlpd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_count_store (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  rlpd_back #(
    .KERNEL_MAX  (KERNEL_MAX),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_LINES   (MAX_LINES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev_valid          (ev_valid),
    .ev_data           (ev_rdata),
    .ev_pop            (ev_pop),
    .reject_limit      (reject_limit_r),
    .cs_raddr          (cs_raddr),
    .cs_rdata          (cs_rdata),
    .done              (back_done),
    .out_valid         (out_valid),
    .out_line_position (out_line_position),
    .out_line_count    (out_line_count),
    .out_row_end       (out_row_end),
    .out_overflow      (out_overflow)
  );

  // Line positions only leave during row-end processing.
  a_pos_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_end |-> busy)
    else $error("line position emitted outside row-end processing");

  // The summary beat coincides with the block becoming ready again.
  a_summary_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> !busy)
    else $error("summary emitted while still busy");

  // The idle back end drains one event per cycle; the queue must never overrun.
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !ev_push)
    else $error("event queue overrun");

endmodule

[tb/tb_row_line_position_detector.sv]
// Self-checking testbench of the row line position detector: directed and random rows.
`timescale 1ns / 1ps
module tb_row_line_position_detector;
  import rlpd_pkg::*;

  localparam int KMAX   = KERNEL_MAX_DEF;
  localparam int HW     = (KMAX - 1) / 2;
  localparam int WIN    = 2 * HW + 1;
  localparam int DLT    = KMAX / 2;
  localparam int MAXW   = MAX_WIDTH_DEF;
  localparam int MAXC   = MAX_CENTERS_DEF;
  localparam int MAXL   = MAX_LINES_DEF;

  // Register indexes not in the package: one past the list, to show it is ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [LCNT_W-1:0] count;
    logic              row_end;
    logic              overflow;
  } line_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_pixel = '0;
  logic in_row_last = 1'b0;
  logic out_valid;
  logic [POS_W-1:0] out_line_position;
  logic [LCNT_W-1:0] out_line_count;
  logic out_row_end;
  logic out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  row_line_position_detector dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel(in_pixel), .in_row_last(in_row_last),
    .out_valid(out_valid), .out_line_position(out_line_position),
    .out_line_count(out_line_count), .out_row_end(out_row_end),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the detector's row state and registers.
  logic [CNT_W-1:0] pm_min_count;
  logic [ACC_W-1:0] pm_reject;
  logic [7:0]       pm_window [WIN];
  logic [4:0]       pm_counts [MAXW];
  int               pm_centers [MAXC];
  int pm_ncenters, pm_run_start, pm_col, pm_fed, pm_accepted;
  bit pm_run_open, pm_dropped;

  line_beat_t expected_lines[$];
  int errors = 0;

  function automatic void clear_row_state();
    for (int i = 0; i < WIN; i++) pm_window[i] = '0;
    pm_ncenters = 0; pm_run_start = 0; pm_run_open = 0;
    pm_col = 0; pm_fed = 0; pm_accepted = 0; pm_dropped = 0;
  endfunction

  function automatic void end_run(int stop_col);
    if (pm_ncenters < MAXC) begin
      pm_centers[pm_ncenters] = pm_run_start + (stop_col - pm_run_start) / 2;
      pm_ncenters++;
    end else begin
      pm_dropped = 1;
    end
    pm_run_open = 0;
  endfunction

  // Shifts one value into the box window; the window then completes the count
  // of the column HW places behind the newest pixel.
  function automatic void shift_box(logic [7:0] v);
    int sum, x, cnt;
    sum = 0;
    for (int i = WIN - 1; i > 0; i--) pm_window[i] = pm_window[i-1];
    pm_window[0] = v;
    pm_fed++;
    if (pm_fed < HW + 1) return;
    x = pm_fed - 1 - HW;
    if (x >= pm_col || x >= MAXW) return;
    for (int i = 0; i < WIN; i++) sum += pm_window[i];
    cnt = sum / 255;
    pm_counts[x] = cnt[4:0];
    if (cnt > pm_min_count && cnt <= KMAX) begin
      if (!pm_run_open) begin
        pm_run_open = 1;
        pm_run_start = x;
      end
    end else if (pm_run_open) begin
      end_run(x);
    end
  endfunction

  // Advances the predictor by one pixel beat and queues the lines it yields.
  function automatic void predict_pixel(logic [7:0] px, logic last);
    int width, c, s;
    line_beat_t b;
    if (pm_col < MAXW) begin
      pm_col++;
      shift_box(px);
    end else begin
      pm_dropped = 1;
    end
    if (!last) return;
    width = pm_col;
    for (int i = 0; i < HW; i++) shift_box(8'd0);
    if (pm_run_open) end_run(width);
    for (int i = 0; i < pm_ncenters; i++) begin
      c = pm_centers[i];
      if (!(c > DLT && c + DLT < width)) continue;
      s = 0;
      for (int k = c - DLT; k <= c + DLT; k++) s += pm_counts[k];
      if (s >= pm_reject) continue;
      if (pm_accepted < MAXL) begin
        b = '{position: c[POS_W-1:0], count: '0, row_end: 1'b0, overflow: 1'b0};
        expected_lines.push_back(b);
        pm_accepted++;
      end else begin
        pm_dropped = 1;
      end
    end
    b = '{position: '0, count: pm_accepted[LCNT_W-1:0], row_end: 1'b1,
          overflow: pm_dropped};
    expected_lines.push_back(b);
    clear_row_state();
  endfunction

  // Result monitor. Each strobe is one beat and must match the oldest expectation.
  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected beat pos=%0d cnt=%0d end=%0b ovf=%0b", $time,
                 out_line_position, out_line_count, out_row_end, out_overflow);
        errors++;
      end else begin
        want = expected_lines.pop_front();
        if (out_line_position !== want.position) begin
          $display("%0t: line_position expected %0d actual %0d", $time,
                   want.position, out_line_position);
          errors++;
        end
        if (out_line_count !== want.count) begin
          $display("%0t: line_count expected %0d actual %0d", $time,
                   want.count, out_line_count);
          errors++;
        end
        if (out_row_end !== want.row_end) begin
          $display("%0t: row_end expected %0b actual %0b", $time,
                   want.row_end, out_row_end);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   want.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  // Sender burst control: a burst of beats, then a random gap.
  int burst_left = 0;
  bit quiet_mode = 0;

  // Drives one pixel beat and waits for the edge that takes it. Inputs move on
  // the falling edge only, so start is never dropped and raised in one step.
  task automatic send_pixel(input logic [7:0] px, input logic last);
    int gap;
    if (!quiet_mode) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    start <= 1'b1;
    in_pixel <= px;
    in_row_last <= last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_pixel(px, last);
    @(negedge clk);
  endtask

  // Waits out every expected beat, then lets the row-end walk settle.
  task automatic drain();
    start <= 1'b0;
    while (expected_lines.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == REG_MIN_COUNT) pm_min_count = value[CNT_W-1:0];
    else if (idx == REG_REJECT_LIMIT) pm_reject = value[ACC_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One row of width w built from bright stripes over a dark or noisy floor.
  task automatic send_striped_row(input int w, input bit noisy);
    int stripe_gap, stripe_len, col_in_period;
    logic [7:0] px;
    stripe_gap = $urandom_range(8, 40);
    stripe_len = $urandom_range(1, 8);
    for (int i = 0; i < w; i++) begin
      col_in_period = i % (stripe_gap + stripe_len);
      if (col_in_period < stripe_len) px = 8'd255 - 8'($urandom_range(0, noisy ? 60 : 0));
      else px = noisy ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
      send_pixel(px, i == w - 1);
    end
  endtask

  // Directed rows: each entry is (pixel, last). Checked by the predictor; the
  // summary beat of a single-pixel row is known at a glance: no line, no flag.
  typedef struct { logic [7:0] px; logic last; } pixel_row_t;
  pixel_row_t directed [] = '{
    '{8'd0,   1'b1},
    '{8'd255, 1'b1},
    '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0},
    '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0},
    '{8'd255, 1'b0}, '{8'd255, 1'b0}, '{8'd255, 1'b0}, '{8'd255, 1'b0},
    '{8'd170, 1'b0}, '{8'd85, 1'b0},
    '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd0, 1'b0},
    '{8'd0, 1'b0}, '{8'd0, 1'b0}, '{8'd1, 1'b1}
  };

  initial begin
    int n;
    pm_min_count = MIN_COUNT_RST;
    pm_reject = REJECT_RST;
    for (int i = 0; i < MAXW; i++) pm_counts[i] = '0;
    clear_row_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first row is one dark pixel: an empty summary.
    expected_lines.push_back('{position: '0, count: '0, row_end: 1'b1, overflow: 1'b0});
    start <= 1'b1; in_pixel <= directed[0].px; in_row_last <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    drain();
    quiet_mode = 1;
    for (int i = 1; i < directed.size(); i++) send_pixel(directed[i].px, directed[i].last);
    drain();
    quiet_mode = 0;

    // Register extremes, with dense stripes so many lines meet the limits.
    write_reg(REG_MIN_COUNT, 0);
    write_reg(REG_REJECT_LIMIT, 1023);
    write_reg(REG_UNUSED, 5);
    send_striped_row(60, 0);
    drain();
    write_reg(REG_MIN_COUNT, 31);
    write_reg(REG_REJECT_LIMIT, 0);
    send_striped_row(30, 1);
    drain();

    // Random part: mostly striped rows under a few settings, some noise rows.
    write_reg(REG_MIN_COUNT, MIN_COUNT_RST);
    write_reg(REG_REJECT_LIMIT, REJECT_RST);
    n = 0;
    while (n < 150) begin
      int w;
      w = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < w; i++) send_pixel(8'($urandom_range(0, 255)), i == w - 1);
      end else begin
        send_striped_row(w, 1'($urandom_range(0, 1)));
      end
      n += w;
      if ($urandom_range(0, 4) == 0) begin
        drain();
        write_reg(REG_MIN_COUNT, $urandom_range(0, 31));
        write_reg(REG_REJECT_LIMIT, $urandom_range(0, 1023));
      end
    end
    drain();

    // Alternating grey levels make every other column a one-column run, so
    // the row holds more lines than the MAX_LINES limit lets out.
    write_reg(REG_MIN_COUNT, 0);
    write_reg(REG_REJECT_LIMIT, 1023);
    for (int i = 0; i < 100; i++)
      send_pixel((i % 2 == 0) ? 8'd25 : 8'd8, i == 99);

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
